// ===== src/ypw_pkg.sv =====
// Shared widths, register codes and constants of the yaw PID controller.
package ypw_pkg;

  localparam int MEAS_W     = 15;
  localparam int SP_W       = 15;
  localparam int WRAP_W     = 14;
  localparam int GAIN_W     = 16;
  localparam int INTEG_W    = 32;
  localparam int LIM_W      = 15;
  localparam int ERR_W      = 18;
  localparam int DIFF_W     = 19;
  localparam int DRIVE_W    = 16;
  localparam int TDATA_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MCAND_W = 32;
  localparam int FRAC_W  = 8;
  localparam int PROD_W  = MCAND_W + GAIN_W - FRAC_W;
  localparam int MCNT_W  = $clog2(GAIN_W + 1);

  localparam logic [WRAP_W-1:0] WRAP_RESET  = 14'd11520;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_POINT   = 3'd0,
    REG_WRAP_ANGLE  = 3'd1,
    REG_GAIN_P      = 3'd2,
    REG_GAIN_I      = 3'd3,
    REG_GAIN_D      = 3'd4,
    REG_INTEG_UPPER = 3'd5,
    REG_INTEG_LOWER = 3'd6,
    REG_DRIVE_LIMIT = 3'd7
  } cfg_reg_t;

endpackage

// ===== src/ypw_serial_mul.sv =====
// Shift-add multiplier: signed multiplicand times unsigned Q8.8 gain, one gain bit per cycle.
module ypw_serial_mul import ypw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic        [GAIN_W-1:0]  gain,
  output logic                      done,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [MCAND_W:0]   hi;
  logic signed [MCAND_W:0]   hi_sum;
  logic        [GAIN_W-1:0]  lo;
  logic signed [MCAND_W-1:0] mc;
  logic        [MCNT_W-1:0]  cnt;
  logic [MCAND_W+GAIN_W:0]   full;

  assign hi_sum = lo[0] ? hi + {mc[MCAND_W-1], mc} : hi;
  assign full   = {hi, lo};
  assign prod   = signed'(full[MCAND_W+GAIN_W-1:FRAC_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == MCNT_W'(1));
      if (start) begin
        hi  <= '0;
        lo  <= gain;
        mc  <= mcand;
        cnt <= MCNT_W'(GAIN_W);
      end else if (cnt != '0) begin
        hi   <= {hi_sum[MCAND_W], hi_sum[MCAND_W:1]};
        lo   <= {hi_sum[0], lo[GAIN_W-1:1]};
        cnt  <= cnt - 1'b1;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> cnt == '0)
    else $error("multiplier restarted while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> cnt == '0 && $past(cnt) == MCNT_W'(1))
    else $error("multiplier done without finishing");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MCNT_W'(GAIN_W))
    else $error("multiplier count beyond gain width");

endmodule

// ===== src/ypw_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, for the derivative mean.
module ypw_serial_div #(
  parameter int DW = 21,
  parameter int VW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          valid,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    q;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dv;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      sh;
  logic [VW:0]      diff;
  logic             ge;

  assign sh       = {rem, q[DW-1]};
  assign ge       = sh >= {1'b0, dv};
  assign diff     = sh - {1'b0, dv};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      valid <= 1'b0;
    end else if (start) begin
      q     <= dividend;
      rem   <= '0;
      dv    <= divisor;
      cnt   <= CNT_W'(DW);
      valid <= 1'b0;
    end else if (cnt != '0) begin
      rem <= ge ? diff[VW-1:0] : sh[VW-1:0];
      q   <= {q[DW-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        valid <= 1'b1;
      end
    end
  end

endmodule

// ===== src/yaw_pid_with_wrap_core.sv =====
// Top level of the yaw PID controller with angle wrap: sequencer, state and ports.
//
//   channel  | direction | handshake              | payload
//   s_axis   | in        | s_axis_tvalid/tready   | tdata[14:0] measured_angle
//   m_axis   | out       | m_axis_tvalid/tready   | tdata[15:0] drive
//   cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// The next request can be taken in the cycle after the drive value is loaded.
// The three gain products share one shift-add multiplier, one after another; the
// derivative mean divider runs alongside the first two of them.
// A new request is taken once the sequencer is back to idle; a held result in
// the output register only stalls the final load. Reset is synchronous and
// needs no clearing pass. cfg_ready is always high.
module yaw_pid_with_wrap_core import ypw_pkg::*; #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [14:0] measured_angle, [15] zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [15:0] drive
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUMW = DIFF_W + $clog2(HISTORY_DEPTH);
  localparam logic [CW-1:0] FILL_MAX = CW'(HISTORY_DEPTH);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_ERR   = 12'b0000_0000_0010,
    ST_FOLD  = 12'b0000_0000_0100,
    ST_HIST  = 12'b0000_0000_1000,
    ST_INTEG = 12'b0000_0001_0000,
    ST_DIVGO = 12'b0000_0010_0000,
    ST_MULP  = 12'b0000_0100_0000,
    ST_MULI  = 12'b0000_1000_0000,
    ST_MULDW = 12'b0001_0000_0000,
    ST_MULD  = 12'b0010_0000_0000,
    ST_ADD   = 12'b0100_0000_0000,
    ST_CLAMP = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  logic signed [SP_W-1:0]    target_angle;
  logic        [WRAP_W-1:0]  wrap_angle;
  logic        [GAIN_W-1:0]  gain_p;
  logic        [GAIN_W-1:0]  gain_i;
  logic        [GAIN_W-1:0]  gain_d;
  logic signed [INTEG_W-1:0] integ_upper;
  logic signed [INTEG_W-1:0] integ_lower;
  logic        [LIM_W-1:0]   drive_limit;

  logic signed [INTEG_W-1:0] accum;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [DIFF_W-1:0]  hist [HISTORY_DEPTH];
  logic        [CW-1:0]      fill;

  logic signed [MEAS_W-1:0]  meas;
  logic signed [ERR_W-1:0]   err;
  logic                      wrapf;
  logic signed [INTEG_W:0]   acc_raw;
  logic signed [SUMW-1:0]    sum;
  logic signed [DRIVE_W-1:0] pterm;
  logic signed [PROD_W-1:0]  ival;
  logic signed [PROD_W:0]    s1;
  logic signed [PROD_W+1:0]  total;
  logic signed [DRIVE_W-1:0] drive;

  logic signed [ERR_W-1:0]   err0;
  logic signed [ERR_W-1:0]   wrap_s;
  logic signed [ERR_W-1:0]   two_w;
  logic signed [ERR_W-1:0]   meas_adj;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [INTEG_W:0]   upper_x;
  logic signed [INTEG_W:0]   lower_x;
  logic signed [INTEG_W-1:0] acc_clamped;
  logic signed [SUMW-1:0]    sum_c;
  logic        [SUMW-1:0]    sum_mag;
  logic        [SUMW-1:0]    quot;
  logic signed [SUMW-1:0]    mean;
  logic signed [PROD_W-1:0]  plim;
  logic signed [DRIVE_W-1:0] pterm_next;
  logic signed [PROD_W+1:0]  tlim;
  logic signed [DRIVE_W-1:0] drive_next;

  logic                      mul_start;
  logic signed [MCAND_W-1:0] mul_mcand;
  logic        [GAIN_W-1:0]  mul_gain;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_prod;
  logic                      div_valid;
  logic                      in_req;
  logic                      out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_CLAMP) && (!m_axis_tvalid || m_axis_tready);
  assign m_axis_tdata  = drive;

  // error and wrap fold
  assign err0     = ERR_W'(target_angle) - ERR_W'(meas);
  assign wrap_s   = signed'(ERR_W'(wrap_angle));
  assign two_w    = signed'(ERR_W'({wrap_angle, 1'b0}));
  assign meas_adj = (meas > 0) ? ERR_W'(meas) - two_w : ERR_W'(meas) + two_w;
  assign diff     = DIFF_W'(err) - DIFF_W'(prev_err);

  // integrator clamp
  assign upper_x = (INTEG_W + 1)'(integ_upper);
  assign lower_x = (INTEG_W + 1)'(integ_lower);
  always_comb begin
    if (acc_raw > upper_x) begin
      acc_clamped = integ_upper;
    end else if (acc_raw < lower_x) begin
      acc_clamped = integ_lower;
    end else begin
      acc_clamped = acc_raw[INTEG_W-1:0];
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if ((CW + 1)'(i) < {1'b0, fill}) begin
        sum_c = sum_c + SUMW'(hist[i]);
      end
    end
  end

  assign sum_mag = sum[SUMW-1] ? -sum : sum;
  assign mean    = sum[SUMW-1] ? signed'(-quot) : signed'(quot);

  // P term clamp
  assign plim = signed'(PROD_W'({1'b0, drive_limit}));
  always_comb begin
    if (mul_prod > plim) begin
      pterm_next = DRIVE_W'(plim);
    end else if (mul_prod < -plim) begin
      pterm_next = DRIVE_W'(-plim);
    end else begin
      pterm_next = DRIVE_W'(mul_prod);
    end
  end

  // output clamp
  assign tlim = signed'((PROD_W + 2)'({1'b0, drive_limit}));
  always_comb begin
    if (total > tlim) begin
      drive_next = DRIVE_W'(tlim);
    end else if (total < -tlim) begin
      drive_next = DRIVE_W'(-tlim);
    end else begin
      drive_next = DRIVE_W'(total);
    end
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      ST_HIST: begin
        mul_mcand = MCAND_W'(err);
        mul_gain  = gain_p;
      end
      ST_MULP: begin
        mul_mcand = MCAND_W'(accum);
        mul_gain  = gain_i;
      end
      default: begin
        mul_mcand = MCAND_W'(mean);
        mul_gain  = gain_d;
      end
    endcase
  end

  assign mul_start = (state == ST_HIST) || (state == ST_MULP && mul_done) ||
                     (state == ST_MULDW && div_valid);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_req) state_next = ST_ERR;
      ST_ERR:   state_next = ST_FOLD;
      ST_FOLD:  state_next = ST_HIST;
      ST_HIST:  state_next = ST_INTEG;
      ST_INTEG: state_next = ST_DIVGO;
      ST_DIVGO: state_next = ST_MULP;
      ST_MULP:  if (mul_done) state_next = ST_MULI;
      ST_MULI:  if (mul_done) state_next = ST_MULDW;
      ST_MULDW: if (div_valid) state_next = ST_MULD;
      ST_MULD:  if (mul_done) state_next = ST_ADD;
      ST_ADD:   state_next = ST_CLAMP;
      ST_CLAMP: if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  ypw_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .mcand (mul_mcand),
    .gain  (mul_gain),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ypw_serial_div #(
    .DW (SUMW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIVGO),
    .dividend (sum_mag),
    .divisor  (fill),
    .valid    (div_valid),
    .quotient (quot)
  );

  // sequencer, controller state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      target_angle  <= '0;
      wrap_angle    <= WRAP_RESET;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      integ_upper   <= '0;
      integ_lower   <= '0;
      drive_limit   <= LIMIT_RESET;
      accum         <= '0;
      prev_err      <= '0;
      fill          <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        drive         <= drive_next;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_req) begin
            meas <= signed'(s_axis_tdata[MEAS_W-1:0]);
          end
        end
        ST_ERR: begin
          err   <= err0;
          wrapf <= (err0 > wrap_s) || (err0 < -wrap_s);
        end
        ST_FOLD: begin
          if (wrapf) begin
            err <= ERR_W'(target_angle) - meas_adj;
          end
        end
        ST_HIST: begin
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist[i] <= hist[i-1];
          end
          hist[0]  <= diff;
          prev_err <= err;
          acc_raw  <= (INTEG_W + 1)'(accum) + (INTEG_W + 1)'(err);
          if (fill != FILL_MAX) begin
            fill <= fill + 1'b1;
          end
        end
        ST_INTEG: begin
          accum <= acc_clamped;
          sum   <= sum_c;
        end
        ST_MULP: begin
          if (mul_done) begin
            pterm <= pterm_next;
          end
        end
        ST_MULI: begin
          if (mul_done) begin
            ival <= mul_prod;
          end
        end
        ST_MULD: begin
          if (mul_done) begin
            s1 <= (PROD_W + 1)'(ival) + (PROD_W + 1)'(mul_prod);
          end
        end
        ST_ADD: begin
          total <= (PROD_W + 2)'(s1) + (PROD_W + 2)'(pterm);
        end
        default: begin
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SET_POINT: begin
            target_angle <= signed'(cfg_data[SP_W-1:0]);
            accum        <= '0;
            prev_err     <= '0;
            fill         <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              hist[i] <= '0;
            end
          end
          REG_WRAP_ANGLE:  wrap_angle  <= cfg_data[WRAP_W-1:0];
          REG_GAIN_P:      gain_p      <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:      gain_i      <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:      gain_d      <= cfg_data[GAIN_W-1:0];
          REG_INTEG_UPPER: integ_upper <= signed'(cfg_data[INTEG_W-1:0]);
          REG_INTEG_LOWER: integ_lower <= signed'(cfg_data[INTEG_W-1:0]);
          REG_DRIVE_LIMIT: drive_limit <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FILL_MAX)
    else $error("history fill beyond depth");

  a_req_starts: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_ERR)
    else $error("accepted request did not start the sequencer");

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_INTEG && !cfg_valid && integ_lower <= integ_upper
    |=> accum <= integ_upper && accum >= integ_lower)
    else $error("integrator outside its limits");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid && state == ST_IDLE)
    else $error("result load lost");

endmodule
